// ===== src/nocpfs_pkg.sv =====
// Shared types and constants for the packet-to-flit sender.
// No dependencies; imported by the sender, its port checker and the bench.
package nocpfs_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_MAX_FLITS   = 64;

   // node identifiers are kept to this many bits before leaving the block
   localparam int NODE_BITS = 8;
   localparam logic [7:0] NODE_MASK = (NODE_BITS >= 8) ? 8'hFF
                                                       : 8'((1 << NODE_BITS) - 1);

   typedef enum logic [1:0] {
      KIND_HEAD = 2'd0,
      KIND_BODY = 2'd1,
      KIND_TAIL = 2'd2
   } flit_kind_type;

   typedef struct packed {
      logic          flit_valid;
      logic [7:0]    flit_src;
      logic [7:0]    flit_dst;
      logic [31:0]   flit_time;
      logic [5:0]    flit_seq;
      flit_kind_type flit_kind;
      logic          req_level;
      logic          dropped;
   } rsp_beat_type;

endpackage

// ===== src/noc_packet_to_flit_sender.sv =====
// Packet-to-flit sender: packet descriptor queue in a synchronous memory, alternating-bit
// flit generation, output register plus skid. Depends on nocpfs_pkg.
// Each rsp beat is registered in the output register, and parked in the skid first while rsp is stalled.
// Throughput: one req beat and one rsp beat per cycle; req stalls while the skid holds a beat.
// Reset (synchronous, active high) clears queue pointers, count, flits left, send level,
// node_id and output valids; the queue memory is not cleared.
module noc_packet_to_flit_sender
   import nocpfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int MAX_FLITS   = DEF_MAX_FLITS
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_inject,
   input  logic [7:0]  req_dest_node,
   input  logic [6:0]  req_packet_flits,
   input  logic [31:0] req_birth_time,
   input  logic        req_ack_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_flit_valid,
   output logic [7:0]  rsp_flit_src,
   output logic [7:0]  rsp_flit_dst,
   output logic [31:0] rsp_flit_time,
   output logic [5:0]  rsp_flit_seq,
   output logic [1:0]  rsp_flit_kind,
   output logic        rsp_req_level,
   output logic        rsp_dropped
);

   localparam int PtrW  = $clog2(QUEUE_DEPTH);
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int LenW  = $clog2(MAX_FLITS + 1);
   localparam int DiffW = (LenW > 6) ? LenW : 6;

   typedef struct packed {
      logic [31:0]     birth_time;
      logic [LenW-1:0] len;
      logic [7:0]      dest;
   } entry_type;

   entry_type queue_mem [QUEUE_DEPTH];
   entry_type rd_q_ff;

   logic [7:0]      node_id_ff;
   logic [PtrW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [LenW-1:0] left_ff, left_in;
   logic            level_ff, level_in;

   rsp_beat_type out_ff, out_in, skid_ff, skid_in, beat;
   logic         out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;

   logic            acc, full, append, send, pop, out_free;
   logic [LenW-1:0] new_len, left_eff;
   logic [DiffW-1:0] diff;
   entry_type       new_entry, front;
   flit_kind_type   kind;

   assign req_stall = skid_vld_ff;
   assign acc       = req_valid && !req_stall;

   // ---- enqueue ----
   always_comb begin
      if (req_packet_flits == 7'd0) begin
         new_len = LenW'(1);
      end else if (int'(req_packet_flits) > MAX_FLITS) begin
         new_len = LenW'(MAX_FLITS);
      end else begin
         new_len = LenW'(req_packet_flits);
      end
   end

   assign new_entry.birth_time = req_birth_time;
   assign new_entry.len        = new_len;
   assign new_entry.dest       = req_dest_node & NODE_MASK;

   assign full   = (count_ff == CntW'(QUEUE_DEPTH));
   assign append = acc && req_inject && !full;

   // ---- queue memory: write at tail, read next head every cycle ----
   always_ff @(posedge clock) begin
      if (append) begin
         queue_mem[tail_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      // forward a same-cycle write to the entry being fetched
      if (append && (tail_ff == head_in)) begin
         rd_q_ff <= new_entry;
      end else begin
         rd_q_ff <= queue_mem[head_in];
      end
   end

   // ---- flit generation ----
   // empty queue: the only possible front packet is the one arriving now
   assign front = (count_ff == '0) ? new_entry : rd_q_ff;
   assign send  = acc && (req_ack_level == level_ff) && ((count_ff != '0) || append);

   assign left_eff = ((left_ff == '0) || (left_ff > front.len)) ? front.len : left_ff;
   assign diff     = DiffW'(front.len) - DiffW'(left_eff);
   assign pop      = send && (left_eff == LenW'(1));

   always_comb begin
      if (left_eff == front.len) begin
         kind = KIND_HEAD;
      end else if (left_eff == LenW'(1)) begin
         kind = KIND_TAIL;
      end else begin
         kind = KIND_BODY;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + CntW'(append) - CntW'(pop);
      left_in  = left_ff;
      level_in = level_ff;
      if (append) begin
         tail_in = (tail_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PtrW'(1);
      end
      if (send) begin
         left_in  = left_eff - LenW'(1);
         level_in = !level_ff;
      end
      if (pop) begin
         head_in = (head_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PtrW'(1);
      end
   end

   always_comb begin
      beat            = '0;
      beat.req_level  = level_in;
      beat.dropped    = req_inject && full;
      beat.flit_kind  = KIND_HEAD;
      if (send) begin
         beat.flit_valid = 1'b1;
         beat.flit_src   = node_id_ff & NODE_MASK;
         beat.flit_dst   = front.dest;
         beat.flit_time  = front.birth_time;
         beat.flit_seq   = diff[5:0];
         beat.flit_kind  = kind;
      end
   end

   // ---- output register and skid ----
   assign out_free = !out_vld_ff || !rsp_stall;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = beat;
            out_vld_in = acc;
         end
      end else if (acc) begin
         // output held: park the new beat
         skid_in     = beat;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         left_ff     <= '0;
         level_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_id_ff <= csr_wr_data;
         end
         if (acc) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            left_ff  <= left_in;
            level_ff <= level_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_flit_valid = out_ff.flit_valid;
   assign rsp_flit_src   = out_ff.flit_src;
   assign rsp_flit_dst   = out_ff.flit_dst;
   assign rsp_flit_time  = out_ff.flit_time;
   assign rsp_flit_seq   = out_ff.flit_seq;
   assign rsp_flit_kind  = out_ff.flit_kind;
   assign rsp_req_level  = out_ff.req_level;
   assign rsp_dropped    = out_ff.dropped;

endmodule

// ===== src/nocpfs_checker.sv =====
// Port-level checks for the packet-to-flit sender, bound to its top level.
// Depends on nocpfs_pkg and on the top level's port names.
module nocpfs_checker
   import nocpfs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_flit_valid,
   input logic [7:0]  rsp_flit_src,
   input logic [7:0]  rsp_flit_dst,
   input logic [31:0] rsp_flit_time,
   input logic [5:0]  rsp_flit_seq,
   input logic [1:0]  rsp_flit_kind,
   input logic        rsp_req_level,
   input logic        rsp_dropped
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_flit_valid)
         && $stable(rsp_flit_src) && $stable(rsp_flit_dst) && $stable(rsp_flit_time)
         && $stable(rsp_flit_seq) && $stable(rsp_flit_kind)
         && $stable(rsp_req_level) && $stable(rsp_dropped))
      else $error("rsp beat changed while stalled");

   // a beat without a flit carries zero flit fields
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_flit_valid |-> rsp_flit_src == 8'd0 && rsp_flit_dst == 8'd0
         && rsp_flit_time == 32'd0 && rsp_flit_seq == 6'd0 && rsp_flit_kind == KIND_HEAD)
      else $error("flit fields not cleared on an empty beat");

   // a head flit always opens its packet
   a_head_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flit_valid && rsp_flit_kind == KIND_HEAD |-> rsp_flit_seq == 6'd0)
      else $error("head flit with nonzero sequence");

   // the request side stalls only after a beat was held on the response side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall && req_valid))
      else $error("req stalled without a held rsp beat");

endmodule

bind noc_packet_to_flit_sender nocpfs_checker u_nocpfs_checker (.*);

// ===== bench/noc_packet_to_flit_sender_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for noc_packet_to_flit_sender: a directed table, then random traffic.
// Each response beat is checked against its typed table row, or else against an in-bench model
// of the packet queue and flit sequencer. Depends on nocpfs_pkg and the sender RTL.
module noc_packet_to_flit_sender_tb
   import nocpfs_pkg::*;
();

   localparam int QDEPTH          = DEF_QUEUE_DEPTH;
   localparam int QPTR_W          = $clog2(QDEPTH);
   localparam int MAXF            = DEF_MAX_FLITS;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DIR_ROWS        = 25;
   localparam int PHASES          = 6;
   localparam int LIMIT_NS        = 4_000_000;

   typedef struct packed {
      logic        inject;
      logic [7:0]  dest;
      logic [6:0]  flits;
      logic [31:0] btime;
      logic        ack;
   } pkt_offer_type;

   typedef struct packed {
      pkt_offer_type offer;
      logic          typed;
      rsp_beat_type  rsp;
   } dir_row_type;

   typedef struct {
      logic [7:0] node_id;
      int         items;
      int         inject_pct;
      int         match_pct;
      int         gap_pct;
      int         stall_pct;
   } phase_type;

   localparam rsp_beat_type UNTYPED = '0;

   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [7:0]  csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_inject       = 1'b0;
   logic [7:0]  req_dest_node    = '0;
   logic [6:0]  req_packet_flits = '0;
   logic [31:0] req_birth_time   = '0;
   logic        req_ack_level    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_flit_valid;
   logic [7:0]  rsp_flit_src;
   logic [7:0]  rsp_flit_dst;
   logic [31:0] rsp_flit_time;
   logic [5:0]  rsp_flit_seq;
   logic [1:0]  rsp_flit_kind;
   logic        rsp_req_level;
   logic        rsp_dropped;

   // packet queue and sequencer as the bench sees them
   logic [7:0]        queued_dest [QDEPTH];
   logic [6:0]        queued_len  [QDEPTH];
   logic [31:0]       queued_time [QDEPTH];
   int                front_left   = 0;
   logic [QPTR_W-1:0] q_head       = '0;
   logic [QPTR_W-1:0] q_tail       = '0;
   int                q_count      = 0;
   logic              flit_level   = 1'b0;
   logic [7:0]        node_id_copy = '0;
   rsp_beat_type      expected_flits [$];

   int fails         = 0;
   bit hold_off_req  = 1'b0;
   int rsp_stall_pct = 25;

   // empty queue, single-flit, zero length, 3-flit walk, then fill to full and drop
   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{1'b0, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 8'h00, 32'h0, 6'd0, KIND_HEAD, 1'b0, 1'b0}},
      '{'{1'b1, 8'hFF, 7'd1, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{1'b1, 8'h00, 8'hFF, 32'hFFFF_FFFF, 6'd0, KIND_HEAD, 1'b1, 1'b0}},
      '{'{1'b1, 8'h00, 7'd0, 32'h0, 1'b1}, 1'b1,
        '{1'b1, 8'h00, 8'h00, 32'h0, 6'd0, KIND_HEAD, 1'b0, 1'b0}},
      '{'{1'b1, 8'h5A, 7'd3, 32'h1234_5678, 1'b1}, 1'b0, UNTYPED},
      '{'{1'b0, 8'hC3, 7'd9, 32'h0F0F_0F0F, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b0, 8'h3C, 7'd0, 32'hF0F0_F0F0, 1'b1}, 1'b0, UNTYPED},
      '{'{1'b0, 8'h00, 7'd2, 32'h0, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h3C, 7'd1, 32'h0000_0001, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h00, 7'd127, 32'hFFFF_FFFE, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'hFF, 7'd64, 32'h7FFF_FFFF, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h01, 7'd65, 32'h8000_0000, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h80, 7'd2, 32'hDEAD_BEEF, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h11, 7'd4, 32'h0000_1111, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h22, 7'd1, 32'h0002_2222, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h33, 7'd0, 32'h0033_3333, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h44, 7'd7, 32'h0444_4444, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h55, 7'd3, 32'h5555_5555, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h66, 7'd1, 32'h6666_6666, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h77, 7'd2, 32'h7777_7777, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h88, 7'd5, 32'h8888_8888, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'h99, 7'd1, 32'h9999_9999, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'hAA, 7'd8, 32'hAAAA_0000, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'hBB, 7'd6, 32'hBBBB_0000, 1'b0}, 1'b0, UNTYPED},
      '{'{1'b1, 8'hAA, 7'd5, 32'h5555_5555, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 8'h00, 32'h0, 6'd0, KIND_HEAD, 1'b1, 1'b1}},
      '{'{1'b1, 8'h55, 7'd3, 32'hAAAA_AAAA, 1'b1}, 1'b1,
        '{1'b1, 8'h00, 8'h3C, 32'h0000_0001, 6'd0, KIND_HEAD, 1'b0, 1'b1}}
   };

   phase_type phases [PHASES] = '{
      '{8'hFF, 160,  8, 85, 20, 20},
      '{8'h00, 160, 40, 70,  0,  0},
      '{8'h5A, 160,  5, 95, 50, 50},
      '{8'hA5, 160, 15, 50, 10, 10},
      '{8'h01, 160, 90, 90, 30, 30},
      '{8'h80, 150,  3, 100, 5,  5}
   };

   noc_packet_to_flit_sender i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_inject       (req_inject),
      .req_dest_node    (req_dest_node),
      .req_packet_flits (req_packet_flits),
      .req_birth_time   (req_birth_time),
      .req_ack_level    (req_ack_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_flit_valid   (rsp_flit_valid),
      .rsp_flit_src     (rsp_flit_src),
      .rsp_flit_dst     (rsp_flit_dst),
      .rsp_flit_time    (rsp_flit_time),
      .rsp_flit_seq     (rsp_flit_seq),
      .rsp_flit_kind    (rsp_flit_kind),
      .rsp_req_level    (rsp_req_level),
      .rsp_dropped      (rsp_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // mostly short idle runs, now and then a long one
   function automatic int idle_run();
      return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
   endfunction

   // append first, then possibly send one flit of the front packet
   task automatic compute_flit(input pkt_offer_type o, output rsp_beat_type r);
      int len;
      r = '0;
      if (o.inject) begin
         if (q_count >= QDEPTH) begin
            r.dropped = 1'b1;
         end else begin
            len = (o.flits == 0) ? 1 : (o.flits > MAXF) ? MAXF : int'(o.flits);
            queued_dest[q_tail] = o.dest & NODE_MASK;
            queued_len[q_tail]  = 7'(len);
            queued_time[q_tail] = o.btime;
            q_tail = QPTR_W'((int'(q_tail) + 1) % QDEPTH);
            q_count++;
         end
      end
      if (o.ack == flit_level && q_count > 0) begin
         len = int'(queued_len[q_head]);
         if (front_left == 0 || front_left > len)
            front_left = len;
         r.flit_valid = 1'b1;
         r.flit_src   = node_id_copy & NODE_MASK;
         r.flit_dst   = queued_dest[q_head];
         r.flit_time  = queued_time[q_head];
         r.flit_seq   = 6'(len - front_left);
         if (front_left == len)
            r.flit_kind = KIND_HEAD;
         else if (front_left == 1)
            r.flit_kind = KIND_TAIL;
         else
            r.flit_kind = KIND_BODY;
         front_left--;
         if (front_left == 0) begin
            q_head = QPTR_W'((int'(q_head) + 1) % QDEPTH);
            q_count--;
         end
         flit_level = ~flit_level;
      end
      r.req_level = flit_level;
   endtask

   function automatic pkt_offer_type random_offer(input int inject_pct, input int match_pct);
      pkt_offer_type o;
      o.inject = ($urandom_range(99) < inject_pct);
      o.dest   = 8'($urandom_range(255));
      o.btime  = $urandom;
      case ($urandom_range(19))
         0:       o.flits = 7'd0;
         1:       o.flits = 7'($urandom_range(127, 65));
         2, 3:    o.flits = 7'($urandom_range(64, 9));
         default: o.flits = 7'($urandom_range(8, 1));
      endcase
      // a well-behaved router mostly answers with the level it was sent
      o.ack = ($urandom_range(99) < match_pct) ? flit_level : ~flit_level;
      return o;
   endfunction

   // entered at a clock edge; returns at the edge where the beat is taken
   task automatic push_beat(input pkt_offer_type o, input int gap, input logic typed,
                            input rsp_beat_type typed_rsp);
      rsp_beat_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_inject       <= o.inject;
      req_dest_node    <= o.dest;
      req_packet_flits <= o.flits;
      req_birth_time   <= o.btime;
      req_ack_level    <= o.ack;
      do @(posedge clock); while (req_stall);
      compute_flit(o, predicted);
      expected_flits.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_flits();
      req_valid <= 1'b0;
      wait (expected_flits.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node_id(input logic [7:0] value);
      drain_flits();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      node_id_copy = value;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endfunction

   initial begin : rsp_stall_gen
      int run;
      run = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            run = HOLD_OFF_CYCLES;
         end else if (run == 0 && $urandom_range(99) < rsp_stall_pct) begin
            run = idle_run();
         end
         rsp_stall <= (run > 0);
         if (run > 0)
            run--;
      end
   end

   initial begin : flit_monitor
      rsp_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_flits.size() == 0) begin
               $error("response beat with nothing pending");
               fails++;
            end else begin
               want = expected_flits.pop_front();
               check_field("flit_valid", want.flit_valid, rsp_flit_valid);
               check_field("flit_src", want.flit_src, rsp_flit_src);
               check_field("flit_dst", want.flit_dst, rsp_flit_dst);
               check_field("flit_time", want.flit_time, rsp_flit_time);
               check_field("flit_seq", want.flit_seq, rsp_flit_seq);
               check_field("flit_kind", want.flit_kind, rsp_flit_kind);
               check_field("req_level", want.req_level, rsp_req_level);
               check_field("dropped", want.dropped, rsp_dropped);
            end
         end
      end
   end

   initial begin : stimulus
      pkt_offer_type o;
      int gap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[i])
         push_beat(dir_table[i].offer, 0, dir_table[i].typed, dir_table[i].rsp);
      foreach (phases[p]) begin
         write_node_id(phases[p].node_id);
         rsp_stall_pct = phases[p].stall_pct;
         for (int n = 0; n < phases[p].items; n++) begin
            // hold the receiver off while beats keep coming, to back up into req
            if (p == 1 && n == 80)
               hold_off_req = 1'b1;
            // pause the sender until everything is back
            if (p == 2 && n == 80)
               drain_flits();
            o   = random_offer(phases[p].inject_pct, phases[p].match_pct);
            gap = ($urandom_range(99) < phases[p].gap_pct) ? idle_run() : 0;
            push_beat(o, gap, 1'b0, UNTYPED);
         end
      end
      drain_flits();
      repeat (8) @(posedge clock);
      if (fails == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
